// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is active.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== src/abs_pkg.sv =====
package abs_pkg;

    // Geometry limits
    localparam int SRC_MAX_W   = 256;
    localparam int SRC_MAX_H   = 256;
    localparam int DST_MAX     = 4096;

    // Source store
    localparam int ADDR_W      = 16;
    localparam int STORE_DEPTH = 1 << ADDR_W;
    localparam int PIX_W       = 32;

    // Field widths
    localparam int COEF_W      = 24;
    localparam int OFS_W       = 13;
    localparam int DIM_W       = 9;
    localparam int CRD_W       = 12;
    localparam int XY_W        = CRD_W + 2;
    localparam int PROD_W      = XY_W + COEF_W;
    localparam int UV_W        = PROD_W + 1;
    localparam int FRAC_W      = 16;
    localparam int WT_W        = FRAC_W + 1;
    localparam int IX_W        = $clog2(SRC_MAX_W);
    localparam int IY_W        = $clog2(SRC_MAX_H);
    localparam int BASE_W      = DIM_W + IY_W;
    localparam int DST_CMP_W   = 17;

    // Channel layout of an ARGB word
    localparam int ALPHA_BYTE  = 3;
    localparam int BYTE_BITS   = 8;
    localparam int NCOL        = 3;
    localparam int NTAP        = 4;

    // Blend and divide
    localparam int L_W         = WT_W + BYTE_BITS;
    localparam int S_W         = 32;
    localparam int DIV_STAGES  = BYTE_BITS;

    // Configuration port
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = COEF_W;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF_A     = 4'd0,
        CFG_COEF_B     = 4'd1,
        CFG_COEF_C     = 4'd2,
        CFG_COEF_D     = 4'd3,
        CFG_OFFSET_X   = 4'd4,
        CFG_OFFSET_Y   = 4'd5,
        CFG_SRC_WIDTH  = 4'd6,
        CFG_SRC_HEIGHT = 4'd7
    } t_cfg_idx;

    typedef struct packed {
        logic              func;
        logic [ADDR_W-1:0] pixel_addr;
        logic [PIX_W-1:0]  pixel_value;
        logic [CRD_W-1:0]  dst_x;
        logic [CRD_W-1:0]  dst_y;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0] result_pixel;
        logic             inside_res;
    } t_out_item;

    typedef struct packed {
        logic [COEF_W-1:0] coef_a;
        logic [COEF_W-1:0] coef_b;
        logic [COEF_W-1:0] coef_c;
        logic [COEF_W-1:0] coef_d;
        logic [OFS_W-1:0]  offset_x;
        logic [OFS_W-1:0]  offset_y;
        logic [DIM_W-1:0]  src_width;
        logic [DIM_W-1:0]  src_height;
    } t_cfg;

    // Item leaving the address stage, lined up with the store access
    typedef struct packed {
        logic                         valid;
        logic                         func;
        logic [ADDR_W-1:0]            pixel_addr;
        logic [PIX_W-1:0]             pixel_value;
        logic                         ins;
        logic [NTAP-1:0][ADDR_W-1:0]  addr;
        logic [NTAP-1:0][WT_W-1:0]    wt;
    } t_s5;

    // Weighted sums handed to the divider
    typedef struct packed {
        logic                     valid;
        logic                     ins;
        logic [L_W-1:0]           l;
        logic [NCOL-1:0][S_W-1:0] s;
    } t_blend;

    // Divider result
    typedef struct packed {
        logic                           valid;
        logic                           ins;
        logic [L_W-1:0]                 l;
        logic [NCOL-1:0][BYTE_BITS-1:0] q;
    } t_div;

endpackage

// ===== src/affine_bilinear_alpha_sampler_top.sv =====
// Affine bilinear ARGB sampler. Write items (func 0) load 32-bit ARGB pixels
// into a 64K-entry source store; sample items (func 1) map a destination
// (x, y) through u = (x+ox)*a + (y+oy)*b, v = (x+ox)*c + (y+oy)*d in Q8.16,
// and return one item: zero with inside_res low when (u, v) falls outside
// [0, w-1) x [0, h-1), otherwise the alpha-weighted bilinear blend of the four
// neighbors (zero pixel with inside_res high when the blended alpha is zero).
// Writes return nothing. The block takes one item every clock while not
// stalled; a sample's result passes 17 register stages: five address
// stages (offset, multiply, sum, range check, address/weight), one store
// read, two blend stages, eight divider stages (one quotient bit each),
// then the output register. The store is four identical copies so the
// four neighbors are read in the same cycle; each write item updates all
// copies at the read stage, so items see the store in their accept order.
// The store is not cleared: sample only written pixels. When the output
// register holds an item and i_out_stall is high the whole pipeline
// freezes and o_in_stall rises. The user must write registers only while
// idle; the block does not enforce this. o_cfg_ready is always high.
`include "assert_macros.svh"

module affine_bilinear_alpha_sampler_top import abs_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // item input
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    // result output
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item,
    // register writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // ---------------- configuration registers ----------------
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.coef_a     <= COEF_W'(1 << FRAC_W);
            r_cfg.coef_b     <= '0;
            r_cfg.coef_c     <= '0;
            r_cfg.coef_d     <= COEF_W'(1 << FRAC_W);
            r_cfg.offset_x   <= '0;
            r_cfg.offset_y   <= '0;
            r_cfg.src_width  <= DIM_W'(256);
            r_cfg.src_height <= DIM_W'(256);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_COEF_A:     r_cfg.coef_a     <= i_cfg_data;
                CFG_COEF_B:     r_cfg.coef_b     <= i_cfg_data;
                CFG_COEF_C:     r_cfg.coef_c     <= i_cfg_data;
                CFG_COEF_D:     r_cfg.coef_d     <= i_cfg_data;
                CFG_OFFSET_X:   r_cfg.offset_x   <= i_cfg_data[OFS_W-1:0];
                CFG_OFFSET_Y:   r_cfg.offset_y   <= i_cfg_data[OFS_W-1:0];
                CFG_SRC_WIDTH:  r_cfg.src_width  <= i_cfg_data[DIM_W-1:0];
                CFG_SRC_HEIGHT: r_cfg.src_height <= i_cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // ---------------- pipeline enable ----------------
    // Single freeze signal: everything advances unless a held result is
    // being stalled by the consumer.
    logic en;
    logic r_out_valid;
    t_out_item r_out, n_out;

    assign en         = !(r_out_valid && i_out_stall);
    assign o_in_stall = !en;

    // ---------------- address and weight stages ----------------
    t_s5 s5;

    abs_addr u_addr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_item  (i_in_item),
        .i_cfg   (r_cfg),
        .o_s5    (s5)
    );

    // ---------------- source store, one copy per neighbor ----------------
    logic                       ram_we;
    logic [NTAP-1:0][PIX_W-1:0] px;

    assign ram_we = en && s5.valid && (s5.func == FUNC_WRITE);

    for (genvar k = 0; k < NTAP; k++) begin : g_store
        abs_ram #(
            .WIDTH (PIX_W),
            .DEPTH (STORE_DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (ram_we),
            .i_waddr (s5.pixel_addr),
            .i_wdata (s5.pixel_value),
            .i_re    (en),
            .i_raddr (s5.addr[k]),
            .o_rdata (px[k])
        );
    end

    // ---------------- blend ----------------
    t_blend blend;

    abs_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_s5    (s5),
        .i_px    (px),
        .o_b     (blend)
    );

    // ---------------- color divide ----------------
    t_div div;

    abs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_b     (blend),
        .o_d     (div)
    );

    // ---------------- pack and output register ----------------
    logic [BYTE_BITS-1:0] alpha;
    logic                 opaque;

    assign alpha  = div.l[FRAC_W +: BYTE_BITS];
    assign opaque = (div.l[L_W-1:FRAC_W] != '0);

    always_comb begin
        n_out.inside_res   = div.ins;
        n_out.result_pixel = '0;
        if (div.ins && opaque) begin
            n_out.result_pixel = {alpha, div.q[2], div.q[1], div.q[0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= div.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // ---------------- checks ----------------
    `ASSERT_IMP(a_outside_zero, i_clk, i_rst_n, o_out_valid && !o_out_item.inside_res, o_out_item.result_pixel == '0)
    `ASSERT_IMP(a_clear_zero, i_clk, i_rst_n, o_out_valid && (o_out_item.result_pixel[31:24] == 8'd0), o_out_item.result_pixel == '0)
    `ASSERT_IMP(a_no_write_frozen, i_clk, i_rst_n, o_in_stall, !ram_we)
    `ASSERT_NEXT(a_div_to_out, i_clk, i_rst_n, !o_in_stall && div.valid, o_out_valid)

endmodule

// ===== src/abs_ram.sv =====
module abs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/abs_addr.sv =====
module abs_addr import abs_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  logic     i_valid,
    input  t_in_item i_item,
    input  t_cfg     i_cfg,
    output t_s5      o_s5
);

    logic [DIM_W-1:0] w_sat;
    logic [DIM_W-1:0] h_sat;
    logic             dim_ok;

    assign w_sat  = (i_cfg.src_width > DIM_W'(SRC_MAX_W)) ? DIM_W'(SRC_MAX_W) : i_cfg.src_width;
    assign h_sat  = (i_cfg.src_height > DIM_W'(SRC_MAX_H)) ? DIM_W'(SRC_MAX_H) : i_cfg.src_height;
    assign dim_ok = (w_sat >= DIM_W'(2)) && (h_sat >= DIM_W'(2));

    // ---- stage 1: offsets ----
    logic                    r_s1_v;
    t_in_item                r_s1_item;
    logic signed [XY_W-1:0]  r_s1_x, r_s1_y, n_s1_x, n_s1_y;
    logic                    r_s1_dok, n_s1_dok;

    assign n_s1_x = $signed({2'b00, i_item.dst_x}) + $signed({i_cfg.offset_x[OFS_W-1], i_cfg.offset_x});
    assign n_s1_y = $signed({2'b00, i_item.dst_y}) + $signed({i_cfg.offset_y[OFS_W-1], i_cfg.offset_y});
    assign n_s1_dok = ({{(DST_CMP_W-CRD_W){1'b0}}, i_item.dst_x} < DST_CMP_W'(DST_MAX))
                   && ({{(DST_CMP_W-CRD_W){1'b0}}, i_item.dst_y} < DST_CMP_W'(DST_MAX));

    // ---- stage 2: products ----
    logic                     r_s2_v;
    t_in_item                 r_s2_item;
    logic                     r_s2_dok;
    logic signed [PROD_W-1:0] r_s2_pa, r_s2_pb, r_s2_pc, r_s2_pd;
    logic signed [PROD_W-1:0] n_s2_pa, n_s2_pb, n_s2_pc, n_s2_pd;

    assign n_s2_pa = r_s1_x * $signed(i_cfg.coef_a);
    assign n_s2_pb = r_s1_y * $signed(i_cfg.coef_b);
    assign n_s2_pc = r_s1_x * $signed(i_cfg.coef_c);
    assign n_s2_pd = r_s1_y * $signed(i_cfg.coef_d);

    // ---- stage 3: u and v ----
    logic             r_s3_v;
    t_in_item         r_s3_item;
    logic             r_s3_dok;
    logic [UV_W-1:0]  r_s3_u, r_s3_vv, n_s3_u, n_s3_vv;

    assign n_s3_u  = {r_s2_pa[PROD_W-1], r_s2_pa} + {r_s2_pb[PROD_W-1], r_s2_pb};
    assign n_s3_vv = {r_s2_pc[PROD_W-1], r_s2_pc} + {r_s2_pd[PROD_W-1], r_s2_pd};

    // ---- stage 4: range check, integer and fraction split ----
    logic              r_s4_v;
    t_in_item          r_s4_item;
    logic              r_s4_ins, n_s4_ins;
    logic [IX_W-1:0]   r_s4_ix;
    logic [IY_W-1:0]   r_s4_iy;
    logic [FRAC_W-1:0] r_s4_fx, r_s4_fy;
    logic [DIM_W-1:0]  wm1, hm1;

    assign wm1 = w_sat - DIM_W'(1);
    assign hm1 = h_sat - DIM_W'(1);
    assign n_s4_ins = r_s3_dok && dim_ok && !r_s3_u[UV_W-1] && !r_s3_vv[UV_W-1]
                   && (r_s3_u[UV_W-2:0]  < (UV_W-1)'({wm1, {FRAC_W{1'b0}}}))
                   && (r_s3_vv[UV_W-2:0] < (UV_W-1)'({hm1, {FRAC_W{1'b0}}}));

    // ---- stage 5: neighbor addresses and weights ----
    t_s5               r_s5, n_s5;
    logic [BASE_W-1:0] base;
    logic [WT_W-1:0]   fxc, fyc, fxw, fyw;
    logic [2*WT_W-1:0] p0, p1, p2, p3;

    assign base = (BASE_W'(w_sat) * BASE_W'(r_s4_iy)) + BASE_W'(r_s4_ix);
    assign fxw  = {1'b0, r_s4_fx};
    assign fyw  = {1'b0, r_s4_fy};
    assign fxc  = {1'b1, {FRAC_W{1'b0}}} - fxw;
    assign fyc  = {1'b1, {FRAC_W{1'b0}}} - fyw;
    assign p0   = fxc * fyc;
    assign p1   = fxw * fyc;
    assign p2   = fxc * fyw;
    assign p3   = fxw * fyw;

    always_comb begin
        n_s5             = r_s5;
        n_s5.valid       = r_s4_v;
        n_s5.func        = r_s4_item.func;
        n_s5.pixel_addr  = r_s4_item.pixel_addr;
        n_s5.pixel_value = r_s4_item.pixel_value;
        n_s5.ins         = r_s4_ins;
        n_s5.addr[0]     = base[ADDR_W-1:0];
        n_s5.addr[1]     = base[ADDR_W-1:0] + ADDR_W'(1);
        n_s5.addr[2]     = base[ADDR_W-1:0] + ADDR_W'(w_sat);
        n_s5.addr[3]     = base[ADDR_W-1:0] + ADDR_W'(w_sat) + ADDR_W'(1);
        n_s5.wt[0]       = p0[FRAC_W+WT_W-1:FRAC_W];
        n_s5.wt[1]       = p1[FRAC_W+WT_W-1:FRAC_W];
        n_s5.wt[2]       = p2[FRAC_W+WT_W-1:FRAC_W];
        n_s5.wt[3]       = p3[FRAC_W+WT_W-1:FRAC_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v     <= 1'b0;
            r_s2_v     <= 1'b0;
            r_s3_v     <= 1'b0;
            r_s4_v     <= 1'b0;
            r_s5.valid <= 1'b0;
        end else if (i_en) begin
            r_s1_v     <= i_valid;
            r_s2_v     <= r_s1_v;
            r_s3_v     <= r_s2_v;
            r_s4_v     <= r_s3_v;
            r_s5.valid <= n_s5.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_item <= i_item;
            r_s1_x    <= n_s1_x;
            r_s1_y    <= n_s1_y;
            r_s1_dok  <= n_s1_dok;
            r_s2_item <= r_s1_item;
            r_s2_dok  <= r_s1_dok;
            r_s2_pa   <= n_s2_pa;
            r_s2_pb   <= n_s2_pb;
            r_s2_pc   <= n_s2_pc;
            r_s2_pd   <= n_s2_pd;
            r_s3_item <= r_s2_item;
            r_s3_dok  <= r_s2_dok;
            r_s3_u    <= n_s3_u;
            r_s3_vv   <= n_s3_vv;
            r_s4_item <= r_s3_item;
            r_s4_ins  <= n_s4_ins;
            r_s4_ix   <= r_s3_u[FRAC_W+IX_W-1:FRAC_W];
            r_s4_iy   <= r_s3_vv[FRAC_W+IY_W-1:FRAC_W];
            r_s4_fx   <= r_s3_u[FRAC_W-1:0];
            r_s4_fy   <= r_s3_vv[FRAC_W-1:0];
            r_s5.func        <= n_s5.func;
            r_s5.pixel_addr  <= n_s5.pixel_addr;
            r_s5.pixel_value <= n_s5.pixel_value;
            r_s5.ins         <= n_s5.ins;
            r_s5.addr        <= n_s5.addr;
            r_s5.wt          <= n_s5.wt;
        end
    end

    assign o_s5 = r_s5;

endmodule

// ===== src/abs_blend.sv =====
module abs_blend import abs_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  t_s5                        i_s5,
    input  logic [NTAP-1:0][PIX_W-1:0] i_px,
    output t_blend                     o_b
);

    // stage 6: lines up with the store read data
    logic                         r_s6_v, r_s6_ins;
    logic [NTAP-1:0][WT_W-1:0]    r_s6_wt;

    // stage 7: alpha-weighted taps
    logic                                     r_s7_v, r_s7_ins;
    logic [NTAP-1:0][L_W-1:0]                 r_s7_l, n_s7_l;
    logic [NTAP-1:0][NCOL-1:0][BYTE_BITS-1:0] r_s7_col, n_s7_col;

    // stage 8: sums
    t_blend                        r_s8, n_s8;
    logic [L_W+1:0]                lsum;
    logic [NCOL-1:0][S_W+1:0]      ssum;

    always_comb begin
        for (int k = 0; k < NTAP; k++) begin
            n_s7_l[k] = r_s6_wt[k] * i_px[k][ALPHA_BYTE*BYTE_BITS +: BYTE_BITS];
            for (int c = 0; c < NCOL; c++) begin
                n_s7_col[k][c] = i_px[k][c*BYTE_BITS +: BYTE_BITS];
            end
        end
    end

    // Weights sum to at most one, so l stays below 2^24 and each color sum
    // is at most 255 * l; the top bits of the wide sums are always zero.
    always_comb begin
        lsum = '0;
        for (int k = 0; k < NTAP; k++) begin
            lsum = lsum + (L_W+2)'(r_s7_l[k]);
        end
        for (int c = 0; c < NCOL; c++) begin
            ssum[c] = '0;
            for (int k = 0; k < NTAP; k++) begin
                ssum[c] = ssum[c] + ((S_W+2)'(r_s7_l[k]) * (S_W+2)'(r_s7_col[k][c]));
            end
        end
        n_s8.valid  = r_s7_v;
        n_s8.ins    = r_s7_ins;
        n_s8.l      = lsum[L_W-1:0];
        for (int c = 0; c < NCOL; c++) begin
            n_s8.s[c] = ssum[c][S_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_v     <= 1'b0;
            r_s7_v     <= 1'b0;
            r_s8.valid <= 1'b0;
        end else if (i_en) begin
            r_s6_v     <= i_s5.valid && (i_s5.func == FUNC_SAMPLE);
            r_s7_v     <= r_s6_v;
            r_s8.valid <= n_s8.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s6_ins    <= i_s5.ins;
            r_s6_wt     <= i_s5.wt;
            r_s7_ins    <= r_s6_ins;
            r_s7_l      <= n_s7_l;
            r_s7_col    <= n_s7_col;
            r_s8.ins    <= n_s8.ins;
            r_s8.l      <= n_s8.l;
            r_s8.s      <= n_s8.s;
        end
    end

    assign o_b = r_s8;

endmodule

// ===== src/abs_div.sv =====
module abs_div import abs_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  t_blend i_b,
    output t_div   o_d
);

    logic                               r_v   [DIV_STAGES];
    logic                               r_ins [DIV_STAGES];
    logic [L_W-1:0]                     r_l   [DIV_STAGES];
    logic [NCOL-1:0][S_W-1:0]           r_rem [DIV_STAGES];
    logic [NCOL-1:0][BYTE_BITS-1:0]     r_q   [DIV_STAGES];

    // One quotient bit per stage, most significant first.
    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_st
        localparam int SH = DIV_STAGES - 1 - j;
        logic                           v_in, ins_in;
        logic [L_W-1:0]                 l_in;
        logic [NCOL-1:0][S_W-1:0]       rem_in, n_rem;
        logic [NCOL-1:0][BYTE_BITS-1:0] q_in, n_q;
        logic [S_W-1:0]                 dvs;

        if (j == 0) begin : g_first
            assign v_in   = i_b.valid;
            assign ins_in = i_b.ins;
            assign l_in   = i_b.l;
            assign rem_in = i_b.s;
            assign q_in   = '0;
        end else begin : g_next
            assign v_in   = r_v[j-1];
            assign ins_in = r_ins[j-1];
            assign l_in   = r_l[j-1];
            assign rem_in = r_rem[j-1];
            assign q_in   = r_q[j-1];
        end

        assign dvs = S_W'(l_in) << SH;

        always_comb begin
            n_rem = rem_in;
            n_q   = q_in;
            for (int c = 0; c < NCOL; c++) begin
                if (rem_in[c] >= dvs) begin
                    n_rem[c]     = rem_in[c] - dvs;
                    n_q[c][SH]   = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_en) begin
                r_v[j] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ins[j] <= ins_in;
                r_l[j]   <= l_in;
                r_rem[j] <= n_rem;
                r_q[j]   <= n_q;
            end
        end
    end

    assign o_d.valid  = r_v[DIV_STAGES-1];
    assign o_d.ins    = r_ins[DIV_STAGES-1];
    assign o_d.l      = r_l[DIV_STAGES-1];
    assign o_d.q      = r_q[DIV_STAGES-1];

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import abs_pkg::*;

    // Clock and reset
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // DUT signals
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    t_in_item              in_item = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_item;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    affine_bilinear_alpha_sampler_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // Items waiting to be driven, and sampled pixels still owed by the DUT
    t_in_item  pending_q[$];
    t_out_item pixel_q[$];

    // Shadow of the source store and of the register file
    logic [31:0] src_pixels[STORE_DEPTH];
    bit          src_written[STORE_DEPTH];
    longint      gain_a = 65536, gain_b = 0, gain_c = 0, gain_d = 65536;
    longint      shift_x = 0, shift_y = 0;
    int unsigned img_w = 256, img_h = 256;

    int errors = 0;
    int cycle = 0;
    int n_samples = 0, n_inside = 0, n_opaque = 0, n_writes = 0;
    logic in_taken = 1'b0;

    // About 28% idle, except for a long calm window that recurs regularly
    function automatic bit idle_roll();
        if ((cycle % 3000) < 500)
            return 1'b0;
        return $urandom_range(99) < 28;
    endfunction

    // Fully clear and opaque alpha a quarter each, random alpha otherwise
    function automatic logic [31:0] rand_argb();
        logic [31:0] px;
        px = $urandom();
        case ($urandom_range(3))
            0: px[31:24] = 8'h00;
            1: px[31:24] = 8'hFF;
            default: ;
        endcase
        return px;
    endfunction

    task automatic push_write(input int unsigned addr, input logic [31:0] px);
        t_in_item it;
        it = '0;
        it.func = FUNC_WRITE;
        it.pixel_addr = addr[ADDR_W-1:0];
        it.pixel_value = px;
        it.dst_x = CRD_W'($urandom());
        it.dst_y = CRD_W'($urandom());
        src_pixels[addr % STORE_DEPTH] = px;
        src_written[addr % STORE_DEPTH] = 1'b1;
        pending_q.push_back(it);
        n_writes++;
    endtask

    // Queue a sample; any neighbor not yet written gets a write first so an
    // inside sample never reads the store where it holds nothing.
    task automatic push_sample(input int unsigned dx, input int unsigned dy);
        longint X, Y, u, v, fx, fy, base, l, s, q;
        longint wt[4], lk[4];
        int unsigned w, h;
        int unsigned addr[4];
        logic [31:0] px[4];
        t_out_item r;
        t_in_item it;
        r = '0;
        w = (img_w > SRC_MAX_W) ? SRC_MAX_W : img_w;
        h = (img_h > SRC_MAX_H) ? SRC_MAX_H : img_h;
        if (w >= 2 && h >= 2) begin
            X = longint'(dx) + shift_x;
            Y = longint'(dy) + shift_y;
            u = X * gain_a + Y * gain_b;
            v = X * gain_c + Y * gain_d;
            if (u >= 0 && v >= 0 && u < (longint'(w - 1) << 16)
                    && v < (longint'(h - 1) << 16)) begin
                r.inside_res = 1'b1;
                fx = u & 64'hFFFF;
                fy = v & 64'hFFFF;
                base = (u >>> 16) + longint'(w) * (v >>> 16);
                addr[0] = 32'(base % STORE_DEPTH);
                addr[1] = 32'((base + 1) % STORE_DEPTH);
                addr[2] = 32'((base + w) % STORE_DEPTH);
                addr[3] = 32'((base + w + 1) % STORE_DEPTH);
                for (int k = 0; k < 4; k++) begin
                    if (!src_written[addr[k]] || $urandom_range(7) == 0)
                        push_write(addr[k], rand_argb());
                    px[k] = src_pixels[addr[k]];
                end
                wt[0] = ((65536 - fx) * (65536 - fy)) >> 16;
                wt[1] = (fx * (65536 - fy)) >> 16;
                wt[2] = ((65536 - fx) * fy) >> 16;
                wt[3] = (fx * fy) >> 16;
                l = 0;
                for (int k = 0; k < 4; k++) begin
                    lk[k] = wt[k] * px[k][31:24];
                    l += lk[k];
                end
                if ((l >> 16) != 0) begin
                    r.result_pixel[31:24] = 8'((l >> 16) & 255);
                    for (int c = 0; c < 3; c++) begin
                        s = 0;
                        for (int k = 0; k < 4; k++)
                            s += lk[k] * ((px[k] >> (c * 8)) & 255);
                        q = s / l;
                        if (q > 255)
                            q = 255;
                        r.result_pixel[c*8 +: 8] = q[7:0];
                    end
                    n_opaque++;
                end
                n_inside++;
            end
        end
        it = '0;
        it.func = FUNC_SAMPLE;
        it.pixel_addr = ADDR_W'($urandom());
        it.pixel_value = $urandom();
        it.dst_x = dx[CRD_W-1:0];
        it.dst_y = dy[CRD_W-1:0];
        pending_q.push_back(it);
        pixel_q.push_back(r);
        n_samples++;
    endtask

    // Wait until everything queued is accepted and every pixel is back, then
    // let the pipeline drain trailing writes.
    task automatic wait_idle();
        while (pending_q.size() != 0 || in_valid)
            @(posedge i_clk);
        while (pixel_q.size() != 0)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic set_reg(input t_cfg_idx idx, input longint val);
        @(negedge i_clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val[CFG_DATA_W-1:0];
        @(posedge i_clk);
        while (!cfg_ready)
            @(posedge i_clk);
        case (idx)
            CFG_COEF_A:     gain_a = longint'($signed(val[23:0]));
            CFG_COEF_B:     gain_b = longint'($signed(val[23:0]));
            CFG_COEF_C:     gain_c = longint'($signed(val[23:0]));
            CFG_COEF_D:     gain_d = longint'($signed(val[23:0]));
            CFG_OFFSET_X:   shift_x = longint'($signed(val[12:0]));
            CFG_OFFSET_Y:   shift_y = longint'($signed(val[12:0]));
            CFG_SRC_WIDTH:  img_w = 32'(val[8:0]);
            CFG_SRC_HEIGHT: img_h = 32'(val[8:0]);
            default: ;
        endcase
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_warp(input longint a, input longint b, input longint c,
                            input longint d, input longint ox, input longint oy,
                            input longint w, input longint h);
        wait_idle();
        set_reg(CFG_COEF_A, a);
        set_reg(CFG_COEF_B, b);
        set_reg(CFG_COEF_C, c);
        set_reg(CFG_COEF_D, d);
        set_reg(CFG_OFFSET_X, ox);
        set_reg(CFG_OFFSET_Y, oy);
        set_reg(CFG_SRC_WIDTH, w);
        set_reg(CFG_SRC_HEIGHT, h);
    endtask

    // Mostly coordinates near the image, a few anywhere, some noise writes
    task automatic random_samples(input int n, input int unsigned span);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) == 0)
                push_write($urandom_range(STORE_DEPTH - 1), rand_argb());
            if ($urandom_range(19) == 0)
                push_sample($urandom_range(4095), $urandom_range(4095));
            else
                push_sample($urandom_range(span), $urandom_range(span));
        end
    endtask

    // Driver: new item at the falling edge once the previous one is taken
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        in_taken <= in_valid && !in_stall;
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            out_stall <= idle_roll();
            if (!in_valid || in_taken) begin
                if (pending_q.size() != 0 && !idle_roll()) begin
                    in_item <= pending_q.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each delivered item with the oldest expected pixel
    always @(posedge i_clk) begin
        t_out_item exp_px;
        if (i_rst_n && out_valid && !out_stall) begin
            if (pixel_q.size() == 0) begin
                $error("unexpected output item %h", out_item);
                errors++;
            end else begin
                exp_px = pixel_q.pop_front();
                if (out_item.result_pixel !== exp_px.result_pixel) begin
                    $error("result_pixel expected %h actual %h",
                           exp_px.result_pixel, out_item.result_pixel);
                    errors++;
                end
                if (out_item.inside_res !== exp_px.inside_res) begin
                    $error("inside_res expected %b actual %b",
                           exp_px.inside_res, out_item.inside_res);
                    errors++;
                end
            end
        end
    end

    initial begin
        #4000000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed, reset geometry (256x256 identity)
        push_write(0, 32'h00123456);
        push_write(1, 32'h00FFFFFF);
        push_write(256, 32'h00000000);
        push_write(257, 32'h00ABCDEF);
        push_sample(0, 0);              // inside, fully transparent
        push_write(65535, 32'hFFFFFFFF);
        push_sample(254, 254);          // last interpolable corner
        push_sample(255, 0);            // right edge is outside
        push_sample(0, 255);            // bottom edge is outside
        push_sample(4095, 4095);        // far destination
        push_write(65535, 32'h00000000);
        push_sample(253, 254);
        random_samples(80, 260);

        // Scaled and sheared, small image
        set_warp(32'h8000, 32'h1000, -32'h800, 32'h9000, -3, 5, 20, 17);
        random_samples(120, 40);

        // Extreme gains and offsets, smallest image
        set_warp(32'h7FFFFF, -32'h800000, -32'h800000, 32'h7FFFFF, 4095, -4096, 2, 2);
        random_samples(30, 4095);
        set_warp(0, 0, 0, 0, 0, 0, 2, 2);
        random_samples(20, 10);

        // Mirror through negative gains
        set_warp(-65536, 0, 0, -65536, -40, -40, 32, 32);
        random_samples(70, 45);

        // Degenerate then oversized dimensions
        set_warp(65536, 0, 0, 65536, 0, 0, 0, 1);
        random_samples(20, 20);
        set_warp(65536, 0, 0, 65536, 0, 0, 511, 300);
        random_samples(40, 300);

        // Random mild warps
        for (int p = 0; p < 4; p++) begin
            int unsigned w, h;
            w = $urandom_range(3, 32);
            h = $urandom_range(3, 32);
            set_warp($urandom_range(32'h4000, 32'h14000),
                     longint'($urandom_range(32'h8000)) - 32'h4000,
                     longint'($urandom_range(32'h8000)) - 32'h4000,
                     $urandom_range(32'h4000, 32'h14000),
                     longint'($urandom_range(16)) - 8,
                     longint'($urandom_range(16)) - 8, w, h);
            random_samples(70, 2 * (w + h));
        end

        wait_idle();
        $display("Ran %0d samples (%0d inside, %0d opaque) and %0d pixel writes",
                 n_samples, n_inside, n_opaque, n_writes);
        $display("over the reset geometry and ten programmed warps, with random gaps and stalls.");
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
